// ----- hw/rtl/sre_pkg.sv -----
package sre_pkg;

    localparam int MEM_DEPTH_DEF    = 4096;
    localparam int IO_REG_COUNT_DEF = 23;

    localparam int WORD_W    = 32;
    localparam int INSTR_W   = 20;
    localparam int PC_W      = 12;
    localparam int REG_IDX_W = 4;
    localparam int REG_COUNT = 16;

    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 24;

    localparam logic [WORD_W-1:0] IMM_EXT = 32'hFFF0_0000;

    // fixed I/O register indexes
    localparam int IO_RETURN  = 7;
    localparam int IO_LEDS    = 9;
    localparam int IO_DISPLAY = 10;
    localparam int IO_DISKCMD = 14;
    localparam int IO_MONCMD  = 22;

    localparam logic [WORD_W-1:0] DISK_CMD_READ  = 32'd1;
    localparam logic [WORD_W-1:0] DISK_CMD_WRITE = 32'd2;

    typedef enum logic [7:0] {
        OP_ADD  = 8'd0,
        OP_SUB  = 8'd1,
        OP_MUL  = 8'd2,
        OP_AND  = 8'd3,
        OP_OR   = 8'd4,
        OP_XOR  = 8'd5,
        OP_SLL  = 8'd6,
        OP_SRA  = 8'd7,
        OP_SRL  = 8'd8,
        OP_BEQ  = 8'd9,
        OP_BNE  = 8'd10,
        OP_BLT  = 8'd11,
        OP_BGT  = 8'd12,
        OP_BLE  = 8'd13,
        OP_BGE  = 8'd14,
        OP_JAL  = 8'd15,
        OP_LW   = 8'd16,
        OP_SW   = 8'd17,
        OP_RETI = 8'd18,
        OP_IN   = 8'd19,
        OP_OUT  = 8'd20
    } opcode_t;

endpackage

// ----- hw/rtl/simple_risc_execute_unit.sv -----
// Execute unit for a 16-register machine with 20-bit instruction words.
// Input channel s_*: one transfer carries one instruction (instr_word, imm_word, pc).
// Output channel m_*: one transfer per instruction with the pc redirect and the
// I/O side-effect flags.
// Pipeline: register read at accept, execute and memory/IO access in the next
// stage, write-back and flag evaluation in the stage after, then the output
// register, which drives m_*.
// Input: a new instruction is taken only while the execute stage is empty; the
// interlock keeps execute single-occupancy against the registered file read.
// When MEM_DEPTH is not a power of two, lw and sw stay in execute through the
// address reduction steps (reciprocal multiply, then multiply back).
// Reset: register file and I/O registers read as zero through valid bits; the
// data memory is swept to zero after reset, one entry a cycle, and s_tready
// stays low until the sweep ends.
// Stall: a waiting result sits in the output register; the stages behind it
// fill and then hold, and execute may still take an instruction while empty.
module simple_risc_execute_unit #(
    parameter int MEM_DEPTH    = sre_pkg::MEM_DEPTH_DEF,
    parameter int IO_REG_COUNT = sre_pkg::IO_REG_COUNT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // instr_word[19:0], imm_word[39:20], pc[51:40], zero pad
    input  logic [sre_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // branch_taken[0], target_pc[12:1], io_touched[13], led_update[14],
    // display_changed[15], disk_start[16], unknown_op[17], zero pad
    output logic [sre_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int ADDR_W = $clog2(MEM_DEPTH);
    localparam int IO_W   = $clog2(IO_REG_COUNT);
    localparam bit MEM_POW2 = (MEM_DEPTH & (MEM_DEPTH - 1)) == 0;
    // reciprocal for the constant modulo (round-up method, 32-bit numerator)
    localparam logic [63:0] DIV_M =
        (((64'd1 << 32) * ((64'd1 << ADDR_W) - 64'(MEM_DEPTH))) / 64'(MEM_DEPTH)) + 64'd1;

    typedef struct packed {
        logic [7:0]  op;
        logic [3:0]  rd;
        logic [31:0] alu;
        logic [31:0] vd;
        logic        taken;
        logic [11:0] target;
        logic        wb_en;
        logic        is_leds;
        logic        is_disp;
        logic        is_disk;
        logic        in_zero;
        logic        io;
        logic        unknown;
    } s2_t;

    // storage
    logic [31:0] rfa_mem [sre_pkg::REG_COUNT];
    logic [31:0] rfb_mem [sre_pkg::REG_COUNT];
    logic [31:0] dmem [MEM_DEPTH];
    logic [31:0] io_mem [IO_REG_COUNT];

    logic [sre_pkg::REG_COUNT-1:0] rf_valid_reg;
    logic [IO_REG_COUNT-1:0]       io_valid_reg;

    logic              clr_active_reg;
    logic [ADDR_W-1:0] clr_cnt_reg;

    // execute stage
    logic        s1_valid_reg;
    logic [19:0] s1_instr_reg;
    logic [31:0] s1_imm_reg;
    logic [11:0] s1_pc_reg;
    logic [31:0] rs_q_reg, rt_q_reg, rd_q_reg;
    logic        rs_ok_reg, rt_ok_reg, rd_ok_reg;
    logic [1:0]  div_step_reg;
    logic [31:0] t1_reg, qd_reg;

    // write-back stage
    logic        s2_valid_reg;
    s2_t         s2_reg;
    s2_t         s2_next;
    logic [31:0] dm_rdata_reg;
    logic [31:0] io_rdata_reg;
    logic        io_rok_reg;

    // most recent register write, for reads that raced it
    logic        lastwr_valid_reg;
    logic [3:0]  lastwr_idx_reg;
    logic [31:0] lastwr_data_reg;

    logic        m_tvalid_reg;
    logic [23:0] m_tdata_reg;

    logic        accept;
    logic        s1_adv, s1_done, s1_mem_op;
    logic        s2_adv, s2_free;

    logic [7:0]  op;
    logic [3:0]  rd, rs, rt;
    logic [31:0] vd, vs, vt, sum;
    logic [4:0]  sh;
    logic        cond;

    logic [63:0] m_prod;
    logic [31:0] q_est;
    logic [63:0] qd_prod;
    logic [31:0] rem;
    logic [ADDR_W-1:0] dm_addr;

    logic            io_in_range;
    logic [IO_W-1:0] io_idx, io_raddr;

    logic [31:0] io_old, wb_data;
    logic [11:0] target_out;
    logic        leds, disp, disk;
    logic [19:0] in_instr, in_imm;
    logic [11:0] in_pc;

    function automatic logic [31:0] pick_operand(
        input logic [3:0]  idx,
        input logic [31:0] imm,
        input logic [31:0] raw,
        input logic        ok,
        input logic        fwd2_hit,
        input logic [3:0]  fwd2_idx,
        input logic [31:0] fwd2_data,
        input logic        lw_hit,
        input logic [3:0]  lw_idx,
        input logic [31:0] lw_data
    );
        logic [31:0] v;
        v = ok ? raw : 32'd0;
        if (lw_hit && lw_idx == idx)
            v = lw_data;
        if (fwd2_hit && fwd2_idx == idx)
            v = fwd2_data;
        if (idx == 4'd0)
            v = 32'd0;
        else if (idx == 4'd1)
            v = imm;
        return v;
    endfunction

    assign in_instr = s_tdata[19:0];
    assign in_imm   = s_tdata[39:20];
    assign in_pc    = s_tdata[51:40];

    assign s_tready = !clr_active_reg && !s1_valid_reg;
    assign accept   = s_tvalid && s_tready;

    assign s2_adv  = s2_valid_reg && (!m_tvalid_reg || m_tready);
    assign s2_free = !s2_valid_reg || s2_adv;

    assign op = s1_instr_reg[19:12];
    assign rd = s1_instr_reg[11:8];
    assign rs = s1_instr_reg[7:4];
    assign rt = s1_instr_reg[3:0];

    assign s1_mem_op = (op == sre_pkg::OP_LW) || (op == sre_pkg::OP_SW);
    assign s1_done   = !s1_mem_op || MEM_POW2 || (div_step_reg == 2'd2);
    assign s1_adv    = s1_valid_reg && s1_done && s2_free;

    // ---------------- execute ----------------
    always_comb
    begin
        vd = pick_operand(rd, s1_imm_reg, rd_q_reg, rd_ok_reg,
                          s2_valid_reg && s2_reg.wb_en, s2_reg.rd, wb_data,
                          lastwr_valid_reg, lastwr_idx_reg, lastwr_data_reg);
        vs = pick_operand(rs, s1_imm_reg, rs_q_reg, rs_ok_reg,
                          s2_valid_reg && s2_reg.wb_en, s2_reg.rd, wb_data,
                          lastwr_valid_reg, lastwr_idx_reg, lastwr_data_reg);
        vt = pick_operand(rt, s1_imm_reg, rt_q_reg, rt_ok_reg,
                          s2_valid_reg && s2_reg.wb_en, s2_reg.rd, wb_data,
                          lastwr_valid_reg, lastwr_idx_reg, lastwr_data_reg);
        sh  = vt[4:0];
        sum = vs + vt;

        // address reduction: sum mod MEM_DEPTH
        m_prod  = 64'(DIV_M[31:0]) * 64'(sum);
        q_est   = (t1_reg + ((sum - t1_reg) >> 1)) >> (ADDR_W - 1);
        qd_prod = 64'(q_est) * 64'(MEM_DEPTH);
        rem     = sum - qd_reg;
        dm_addr = MEM_POW2 ? sum[ADDR_W-1:0] : rem[ADDR_W-1:0];

        io_in_range = sum < 32'(IO_REG_COUNT);
        io_idx      = sum[IO_W-1:0];
        if (op == sre_pkg::OP_RETI || !io_in_range)
            io_raddr = IO_W'(sre_pkg::IO_RETURN);
        else
            io_raddr = io_idx;

        cond    = 1'b0;
        s2_next = '0;
        s2_next.op = op;
        s2_next.rd = rd;
        s2_next.vd = vd;
        case (op)
            sre_pkg::OP_ADD: begin s2_next.alu = vs + vt; s2_next.wb_en = 1'b1; end
            sre_pkg::OP_SUB: begin s2_next.alu = vs - vt; s2_next.wb_en = 1'b1; end
            sre_pkg::OP_MUL: begin s2_next.alu = vs * vt; s2_next.wb_en = 1'b1; end
            sre_pkg::OP_AND: begin s2_next.alu = vs & vt; s2_next.wb_en = 1'b1; end
            sre_pkg::OP_OR:  begin s2_next.alu = vs | vt; s2_next.wb_en = 1'b1; end
            sre_pkg::OP_XOR: begin s2_next.alu = vs ^ vt; s2_next.wb_en = 1'b1; end
            sre_pkg::OP_SLL: begin s2_next.alu = vs << sh; s2_next.wb_en = 1'b1; end
            sre_pkg::OP_SRA:
            begin
                s2_next.alu   = 32'($signed(vs) >>> sh);
                s2_next.wb_en = 1'b1;
            end
            sre_pkg::OP_SRL: begin s2_next.alu = vs >> sh; s2_next.wb_en = 1'b1; end
            sre_pkg::OP_BEQ, sre_pkg::OP_BNE, sre_pkg::OP_BLT,
            sre_pkg::OP_BGT, sre_pkg::OP_BLE, sre_pkg::OP_BGE:
            begin
                if (op == sre_pkg::OP_BEQ)
                    cond = (vs == vt);
                else if (op == sre_pkg::OP_BNE)
                    cond = (vs != vt);
                else if (op == sre_pkg::OP_BLT)
                    cond = ($signed(vs) < $signed(vt));
                else if (op == sre_pkg::OP_BGT)
                    cond = ($signed(vs) > $signed(vt));
                else if (op == sre_pkg::OP_BLE)
                    cond = ($signed(vs) <= $signed(vt));
                else
                    cond = ($signed(vs) >= $signed(vt));
                s2_next.taken  = cond;
                s2_next.target = cond ? vd[11:0] : 12'd0;
            end
            sre_pkg::OP_JAL:
            begin
                s2_next.alu    = {20'd0, s1_pc_reg} + 32'd1;
                s2_next.wb_en  = 1'b1;
                s2_next.taken  = 1'b1;
                s2_next.target = vs[11:0];
            end
            sre_pkg::OP_LW:   s2_next.wb_en = 1'b1;
            sre_pkg::OP_SW:   s2_next.wb_en = 1'b0;
            sre_pkg::OP_RETI:
            begin
                s2_next.taken = 1'b1;  // target comes from the I/O read
                s2_next.io    = 1'b1;
            end
            sre_pkg::OP_IN:
            begin
                s2_next.wb_en   = 1'b1;
                s2_next.io      = 1'b1;
                s2_next.in_zero = !io_in_range || (sum == 32'(sre_pkg::IO_MONCMD));
            end
            sre_pkg::OP_OUT:
            begin
                s2_next.io      = 1'b1;
                s2_next.is_leds = io_in_range && (sum == 32'(sre_pkg::IO_LEDS));
                s2_next.is_disp = io_in_range && (sum == 32'(sre_pkg::IO_DISPLAY));
                s2_next.is_disk = io_in_range && (sum == 32'(sre_pkg::IO_DISKCMD));
            end
            default: s2_next.unknown = 1'b1;
        endcase
        // registers 0 and 1 are read-only
        s2_next.wb_en = s2_next.wb_en && (rd[3:1] != 3'd0);
    end

    // ---------------- write-back ----------------
    always_comb
    begin
        io_old = io_rok_reg ? io_rdata_reg : 32'd0;
        case (s2_reg.op)
            sre_pkg::OP_LW: wb_data = dm_rdata_reg;
            sre_pkg::OP_IN: wb_data = s2_reg.in_zero ? 32'd0 : io_old;
            default:        wb_data = s2_reg.alu;
        endcase
        target_out = (s2_reg.op == sre_pkg::OP_RETI) ? io_old[11:0] : s2_reg.target;
        leds = s2_reg.is_leds && (io_old != s2_reg.vd);
        disp = s2_reg.is_disp && (io_old != s2_reg.vd);
        disk = s2_reg.is_disk &&
               (s2_reg.vd == sre_pkg::DISK_CMD_READ || s2_reg.vd == sre_pkg::DISK_CMD_WRITE);
    end

    // ---------------- memories ----------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rs_q_reg <= rfa_mem[in_instr[7:4]];
            rt_q_reg <= rfa_mem[in_instr[3:0]];
            rd_q_reg <= rfb_mem[in_instr[11:8]];
        end
        if (s2_adv && s2_reg.wb_en)
        begin
            rfa_mem[s2_reg.rd] <= wb_data;
            rfb_mem[s2_reg.rd] <= wb_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_active_reg)
            dmem[clr_cnt_reg] <= 32'd0;
        else if (s1_adv && op == sre_pkg::OP_SW)
            dmem[dm_addr] <= vd;
        if (s1_adv)
            dm_rdata_reg <= dmem[dm_addr];
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && op == sre_pkg::OP_OUT && io_in_range)
            io_mem[io_idx] <= vd;
        if (s1_adv)
            io_rdata_reg <= io_mem[io_raddr];
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_instr_reg <= in_instr;
            s1_imm_reg   <= in_imm[19] ? (sre_pkg::IMM_EXT | {12'd0, in_imm}) : {12'd0, in_imm};
            s1_pc_reg    <= in_pc;
        end
        if (s1_valid_reg && div_step_reg == 2'd0)
            t1_reg <= m_prod[63:32];
        if (s1_valid_reg && div_step_reg == 2'd1)
            qd_reg <= qd_prod[31:0];
        if (s1_adv)
            s2_reg <= s2_next;
        if (s2_adv && s2_reg.wb_en)
        begin
            lastwr_idx_reg  <= s2_reg.rd;
            lastwr_data_reg <= wb_data;
        end
        if (s2_adv)
            m_tdata_reg <= {6'd0, s2_reg.unknown, disk, disp, leds, s2_reg.io,
                            s2_reg.taken ? target_out : 12'd0, s2_reg.taken};
    end

    // ---------------- control ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg   <= 1'b1;
            clr_cnt_reg      <= '0;
            rf_valid_reg     <= '0;
            io_valid_reg     <= '0;
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            m_tvalid_reg     <= 1'b0;
            div_step_reg     <= 2'd0;
            lastwr_valid_reg <= 1'b0;
            rs_ok_reg        <= 1'b0;
            rt_ok_reg        <= 1'b0;
            rd_ok_reg        <= 1'b0;
            io_rok_reg       <= 1'b0;
        end
        else
        begin
            if (clr_active_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ADDR_W'(MEM_DEPTH - 1))
                    clr_active_reg <= 1'b0;
            end

            if (accept)
            begin
                rs_ok_reg    <= rf_valid_reg[in_instr[7:4]];
                rt_ok_reg    <= rf_valid_reg[in_instr[3:0]];
                rd_ok_reg    <= rf_valid_reg[in_instr[11:8]];
                div_step_reg <= 2'd0;
            end
            else if (s1_valid_reg && s1_mem_op && !MEM_POW2 && div_step_reg != 2'd2)
                div_step_reg <= div_step_reg + 2'd1;

            if (accept)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;

            if (s1_adv)
            begin
                s2_valid_reg <= 1'b1;
                io_rok_reg   <= io_valid_reg[io_raddr];
                if (op == sre_pkg::OP_OUT && io_in_range)
                    io_valid_reg[io_idx] <= 1'b1;
            end
            else if (s2_adv)
                s2_valid_reg <= 1'b0;

            if (s2_adv && s2_reg.wb_en)
            begin
                rf_valid_reg[s2_reg.rd] <= 1'b1;
                lastwr_valid_reg        <= 1'b1;
            end

            if (s2_adv)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ---------------- assertions ----------------
    a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
        clr_active_reg |-> (!s1_valid_reg && !s2_valid_reg && !m_tvalid_reg))
        else $error("pipeline busy during memory clear");

    a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (s1_valid_reg && div_step_reg == 2'd0))
        else $error("accepted transfer did not enter execute");

    a_no_ro_write: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && s2_reg.wb_en) |-> (s2_reg.rd[3:1] != 3'd0))
        else $error("write-back aimed at register 0 or 1");

    a_target_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[12:1] == 12'd0))
        else $error("target_pc set without branch_taken");

    a_unknown_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[17]) |-> (m_tdata[16:0] == 17'd0))
        else $error("unknown opcode raised other flags");

endmodule

// ----- test/simple_risc_execute_unit_tb.sv -----
`timescale 1ns / 1ps

module simple_risc_execute_unit_tb;

    localparam int MEM_DEPTH     = sre_pkg::MEM_DEPTH_DEF;
    localparam int IO_REG_COUNT  = sre_pkg::IO_REG_COUNT_DEF;
    localparam int WORD_W        = sre_pkg::WORD_W;
    localparam int REG_COUNT     = sre_pkg::REG_COUNT;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 16;
    localparam int MAX_REPORTS   = 100;

    localparam logic [3:0] REG_ZERO = 4'd0;
    localparam logic [3:0] REG_IMM  = 4'd1;
    localparam logic [7:0] OP_FIRST_UNKNOWN = 8'd21;

    typedef struct packed {
        logic        unknown_op;
        logic        disk_start;
        logic        display_changed;
        logic        led_update;
        logic        io_touched;
        logic [11:0] target_pc;
        logic        branch_taken;
    } exec_result_t;

    logic                          clk;
    logic                          rst_n;
    logic                          s_tvalid;
    logic                          s_tready;
    // instr_word[19:0], imm_word[39:20], pc[51:40], zero pad
    logic [sre_pkg::S_TDATA_W-1:0] s_tdata;
    logic                          m_tvalid;
    logic                          m_tready;
    // branch_taken[0], target_pc[12:1], io_touched[13], led_update[14],
    // display_changed[15], disk_start[16], unknown_op[17], zero pad
    logic [sre_pkg::M_TDATA_W-1:0] m_tdata;

    // shadow machine state
    logic [WORD_W-1:0] reg_file [REG_COUNT];
    logic [WORD_W-1:0] data_mem [MEM_DEPTH];
    logic [WORD_W-1:0] io_regs  [IO_REG_COUNT];

    exec_result_t pending_results[$];
    exec_result_t exp_res;

    int  errors;
    int  n_sent;
    int  n_checked;
    int  n_taken;
    int  n_io;
    int  n_mem;
    int  n_unknown;
    bit  idle_on;

    simple_risc_execute_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic [WORD_W-1:0] operand_value(input logic [3:0] idx,
                                                        input logic [WORD_W-1:0] imm);
        if (idx == REG_ZERO)
            return '0;
        if (idx == REG_IMM)
            return imm;
        return reg_file[idx];
    endfunction

    function automatic void write_back(input logic [3:0] idx, input logic [WORD_W-1:0] val);
        if (idx != REG_ZERO && idx != REG_IMM)
            reg_file[idx] = val;
    endfunction

    // executes one instruction on the shadow state, returns the expected flags
    function automatic exec_result_t execute_instr(input logic [19:0] word,
                                                   input logic [19:0] imm_raw,
                                                   input logic [11:0] pc);
        logic [7:0]        op;
        logic [3:0]        rd;
        logic [3:0]        rs;
        logic [3:0]        rt;
        logic [WORD_W-1:0] imm;
        logic [WORD_W-1:0] vd;
        logic [WORD_W-1:0] vs;
        logic [WORD_W-1:0] vt;
        logic [WORD_W-1:0] sum;
        logic [WORD_W-1:0] io_val;
        logic [4:0]        sh;
        logic              cond;
        exec_result_t      r;

        op   = word[19:12];
        rd   = word[11:8];
        rs   = word[7:4];
        rt   = word[3:0];
        r    = '0;
        cond = 1'b0;
        imm  = {{12{imm_raw[19]}}, imm_raw};
        vd   = operand_value(rd, imm);
        vs   = operand_value(rs, imm);
        vt   = operand_value(rt, imm);
        sh   = vt[4:0];
        sum  = vs + vt;

        case (op)
            sre_pkg::OP_ADD:  write_back(rd, vs + vt);
            sre_pkg::OP_SUB:  write_back(rd, vs - vt);
            sre_pkg::OP_MUL:  write_back(rd, vs * vt);
            sre_pkg::OP_AND:  write_back(rd, vs & vt);
            sre_pkg::OP_OR:   write_back(rd, vs | vt);
            sre_pkg::OP_XOR:  write_back(rd, vs ^ vt);
            sre_pkg::OP_SLL:  write_back(rd, vs << sh);
            sre_pkg::OP_SRA:  write_back(rd, $unsigned($signed(vs) >>> sh));
            sre_pkg::OP_SRL:  write_back(rd, vs >> sh);
            sre_pkg::OP_BEQ:  cond = (vs == vt);
            sre_pkg::OP_BNE:  cond = (vs != vt);
            sre_pkg::OP_BLT:  cond = ($signed(vs) < $signed(vt));
            sre_pkg::OP_BGT:  cond = ($signed(vs) > $signed(vt));
            sre_pkg::OP_BLE:  cond = ($signed(vs) <= $signed(vt));
            sre_pkg::OP_BGE:  cond = ($signed(vs) >= $signed(vt));
            sre_pkg::OP_JAL:
            begin
                write_back(rd, {20'd0, pc} + 32'd1);
                r.branch_taken = 1'b1;
                r.target_pc    = vs[11:0];
            end
            sre_pkg::OP_LW:
            begin
                write_back(rd, data_mem[sum % MEM_DEPTH]);
                n_mem++;
            end
            sre_pkg::OP_SW:
            begin
                data_mem[sum % MEM_DEPTH] = vd;
                n_mem++;
            end
            sre_pkg::OP_RETI:
            begin
                r.branch_taken = 1'b1;
                r.target_pc    = io_regs[sre_pkg::IO_RETURN][11:0];
                r.io_touched   = 1'b1;
            end
            sre_pkg::OP_IN:
            begin
                io_val = '0;
                if (sum < IO_REG_COUNT && sum != sre_pkg::IO_MONCMD)
                    io_val = io_regs[sum];
                write_back(rd, io_val);
                r.io_touched = 1'b1;
            end
            sre_pkg::OP_OUT:
            begin
                if (sum < IO_REG_COUNT)
                begin
                    if (sum == sre_pkg::IO_LEDS)
                        r.led_update = (io_regs[sum] != vd);
                    else if (sum == sre_pkg::IO_DISPLAY)
                        r.display_changed = (io_regs[sum] != vd);
                    else if (sum == sre_pkg::IO_DISKCMD)
                        r.disk_start = (vd == sre_pkg::DISK_CMD_READ ||
                                        vd == sre_pkg::DISK_CMD_WRITE);
                    io_regs[sum] = vd;
                end
                r.io_touched = 1'b1;
            end
            default: r.unknown_op = 1'b1;
        endcase

        // compare branches redirect to rd
        if (cond)
        begin
            r.branch_taken = 1'b1;
            r.target_pc    = vd[11:0];
        end
        if (r.branch_taken)
            n_taken++;
        if (r.io_touched)
            n_io++;
        if (r.unknown_op)
            n_unknown++;
        return r;
    endfunction

    function automatic logic [19:0] encode(input logic [7:0] op, input logic [3:0] rd,
                                           input logic [3:0] rs, input logic [3:0] rt);
        return {op, rd, rs, rt};
    endfunction

    function automatic logic [19:0] pick_imm();
        case ($urandom_range(0, 7))
            0:       return 20'h00000;
            1:       return 20'h7FFFF;
            2:       return 20'h80000;
            3:       return 20'hFFFFF;
            4:       return 20'($urandom_range(0, 40));
            default: return 20'($urandom);
        endcase
    endfunction

    function automatic logic [19:0] pick_io_index();
        case ($urandom_range(0, 9))
            0:       return 20'(sre_pkg::IO_RETURN);
            1:       return 20'(sre_pkg::IO_LEDS);
            2:       return 20'(sre_pkg::IO_DISPLAY);
            3:       return 20'(sre_pkg::IO_DISKCMD);
            4:       return 20'(sre_pkg::IO_MONCMD);
            5:       return 20'($urandom_range(IO_REG_COUNT, IO_REG_COUNT + 4));
            default: return 20'($urandom_range(0, IO_REG_COUNT - 1));
        endcase
    endfunction

    task automatic hold_off_input();
        @(negedge clk);
        s_tvalid <= 1'b0;
    endtask

    // tvalid stays high after the transfer until the next call or a hold-off
    task automatic send_instr(input logic [19:0] word, input logic [19:0] imm,
                              input logic [11:0] pc);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 14);
            hold_off_input();
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {4'd0, pc, imm, word};
        do
            @(posedge clk);
        while (!s_tready);
        pending_results.push_back(execute_instr(word, imm, pc));
        n_sent++;
    endtask

    task automatic wait_for_results();
        hold_off_input();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
        if (exp_v !== got_v)
        begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h",
                         $time, name, exp_v, got_v);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: result transfer with none expected, expected none, got 0x%0h",
                         $time, m_tdata);
            end
            else
            begin
                exp_res = pending_results.pop_front();
                n_checked++;
                check_field("branch_taken", exp_res.branch_taken, m_tdata[0]);
                check_field("target_pc", exp_res.target_pc, m_tdata[12:1]);
                check_field("io_touched", exp_res.io_touched, m_tdata[13]);
                check_field("led_update", exp_res.led_update, m_tdata[14]);
                check_field("display_changed", exp_res.display_changed, m_tdata[15]);
                check_field("disk_start", exp_res.disk_start, m_tdata[16]);
                check_field("unknown_op", exp_res.unknown_op, m_tdata[17]);
                check_field("pad", '0, m_tdata[sre_pkg::M_TDATA_W-1:18]);
            end
        end
    end

    // output side back-pressure in bursts
    initial
    begin
        int stall_left;
        stall_left = 0;
        m_tready   = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 14) - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // r2 = max positive immediate, r3 = most negative immediate
    task automatic test_alu_ops();
        send_instr(encode(sre_pkg::OP_ADD, 4'd2, REG_IMM, REG_ZERO), 20'h7FFFF, 12'h000);
        send_instr(encode(sre_pkg::OP_ADD, 4'd3, REG_IMM, REG_ZERO), 20'h80000, 12'hFFF);
        send_instr(encode(sre_pkg::OP_SUB, 4'd4, 4'd3, 4'd2), 20'h00000, 12'h001);
        send_instr(encode(sre_pkg::OP_MUL, 4'd5, 4'd3, 4'd2), 20'h00000, 12'h002);
        send_instr(encode(sre_pkg::OP_AND, 4'd6, 4'd3, REG_IMM), 20'hFFFFF, 12'h003);
        send_instr(encode(sre_pkg::OP_OR, 4'd7, 4'd2, 4'd3), 20'h00000, 12'h004);
        send_instr(encode(sre_pkg::OP_XOR, 4'd8, 4'd3, 4'd2), 20'h55555, 12'h005);
        // shift amounts above 31 keep only their low 5 bits
        send_instr(encode(sre_pkg::OP_SLL, 4'd9, 4'd2, REG_IMM), 20'h00024, 12'h006);
        send_instr(encode(sre_pkg::OP_SRA, 4'd10, 4'd3, REG_IMM), 20'h0003F, 12'h007);
        send_instr(encode(sre_pkg::OP_SRL, 4'd11, 4'd3, REG_IMM), 20'h0003F, 12'h008);
    endtask

    task automatic test_branches();
        send_instr(encode(sre_pkg::OP_BEQ, REG_IMM, 4'd2, 4'd2), 20'hFFFFF, 12'h010);
        send_instr(encode(sre_pkg::OP_BNE, 4'd2, 4'd2, 4'd2), 20'h00000, 12'h011);
        send_instr(encode(sre_pkg::OP_BLT, 4'd4, 4'd3, 4'd2), 20'h00000, 12'h012);
        send_instr(encode(sre_pkg::OP_BGT, 4'd5, 4'd3, 4'd2), 20'h00000, 12'h013);
        send_instr(encode(sre_pkg::OP_BLE, 4'd6, 4'd2, 4'd2), 20'h00000, 12'h014);
        send_instr(encode(sre_pkg::OP_BGE, REG_IMM, 4'd3, 4'd2), 20'h00ABC, 12'h015);
        // link to the immediate register is dropped but the jump happens
        send_instr(encode(sre_pkg::OP_JAL, REG_IMM, REG_IMM, REG_ZERO), 20'h00123, 12'hFFF);
    endtask

    task automatic test_memory();
        // -1 + 0 wraps to the top entry
        send_instr(encode(sre_pkg::OP_SW, 4'd2, REG_IMM, REG_ZERO), 20'hFFFFF, 12'h020);
        send_instr(encode(sre_pkg::OP_LW, 4'd14, REG_IMM, REG_ZERO), 20'h00FFF, 12'h021);
    endtask

    task automatic test_io();
        send_instr(encode(sre_pkg::OP_OUT, 4'd2, REG_IMM, REG_ZERO),
                   20'(sre_pkg::IO_LEDS), 12'h030);
        send_instr(encode(sre_pkg::OP_OUT, 4'd3, REG_IMM, REG_ZERO),
                   20'(sre_pkg::IO_DISPLAY), 12'h031);
        send_instr(encode(sre_pkg::OP_ADD, 4'd12, REG_IMM, REG_ZERO), 20'h00001, 12'h032);
        send_instr(encode(sre_pkg::OP_OUT, 4'd12, REG_IMM, REG_ZERO),
                   20'(sre_pkg::IO_DISKCMD), 12'h033);
        // monitor command register reads back as zero
        send_instr(encode(sre_pkg::OP_OUT, 4'd2, REG_IMM, REG_ZERO),
                   20'(sre_pkg::IO_MONCMD), 12'h034);
        send_instr(encode(sre_pkg::OP_IN, 4'd13, REG_IMM, REG_ZERO),
                   20'(sre_pkg::IO_MONCMD), 12'h035);
        send_instr(encode(sre_pkg::OP_OUT, REG_IMM, REG_IMM, REG_ZERO), 20'd25, 12'h036);
        send_instr(encode(sre_pkg::OP_OUT, 4'd2, REG_IMM, REG_ZERO),
                   20'(sre_pkg::IO_RETURN), 12'h037);
        send_instr(encode(sre_pkg::OP_RETI, REG_ZERO, REG_ZERO, REG_ZERO), 20'h00000, 12'h038);
        send_instr(encode(OP_FIRST_UNKNOWN, 4'd7, 4'd8, 4'd9), 20'hFFFFF, 12'h039);
    endtask

    task automatic test_random_traffic(input int n_items, input bit with_idle);
        int         start;
        int         cat;
        logic [3:0] rx;
        logic [7:0] op;
        logic [3:0] rt;

        start   = n_sent;
        idle_on = with_idle;
        while (n_sent - start < n_items)
        begin
            if (with_idle && $urandom_range(0, 99) == 0)
                idle_on = !idle_on;
            cat = $urandom_range(0, 99);
            if (cat < 35)
            begin
                op = 8'($urandom_range(sre_pkg::OP_ADD, sre_pkg::OP_SRL));
                send_instr(encode(op, 4'($urandom), 4'($urandom), 4'($urandom)),
                           pick_imm(), 12'($urandom));
            end
            else if (cat < 50)
            begin
                op = 8'($urandom_range(sre_pkg::OP_BEQ, sre_pkg::OP_JAL));
                send_instr(encode(op, 4'($urandom), 4'($urandom), 4'($urandom)),
                           pick_imm(), 12'($urandom));
            end
            else if (cat < 65)
            begin
                op = $urandom_range(0, 1) ? sre_pkg::OP_LW : sre_pkg::OP_SW;
                rt = $urandom_range(0, 2) == 0 ? 4'($urandom) : REG_ZERO;
                // bias accesses toward a small window at both ends of memory
                send_instr(encode(op, 4'($urandom),
                                  $urandom_range(0, 3) == 0 ? 4'($urandom) : REG_IMM, rt),
                           $urandom_range(0, 3) == 0 ? pick_imm()
                                                     : 20'($urandom_range(0, 15) - 8),
                           12'($urandom));
            end
            else if (cat < 90)
            begin
                // load a value, then move it through an I/O register
                rx = 4'($urandom_range(2, REG_COUNT - 1));
                send_instr(encode(sre_pkg::OP_ADD, rx, REG_IMM, REG_ZERO),
                           $urandom_range(0, 1) ? 20'($urandom_range(0, 3)) : pick_imm(),
                           12'($urandom));
                cat = $urandom_range(0, 9);
                op  = cat < 6 ? sre_pkg::OP_OUT : (cat < 9 ? sre_pkg::OP_IN : sre_pkg::OP_RETI);
                rt  = $urandom_range(0, 3) == 0 ? 4'($urandom) : REG_ZERO;
                send_instr(encode(op, op == sre_pkg::OP_IN ? 4'($urandom) : rx, REG_IMM, rt),
                           pick_io_index(), 12'($urandom));
            end
            else if (cat < 96)
                send_instr(encode(8'($urandom_range(OP_FIRST_UNKNOWN, 255)), 4'($urandom),
                                  4'($urandom), 4'($urandom)),
                           pick_imm(), 12'($urandom));
            else
                send_instr(20'($urandom), 20'($urandom), 12'($urandom));
        end
    endtask

    initial
    begin
        errors    = 0;
        n_sent    = 0;
        n_checked = 0;
        n_taken   = 0;
        n_io      = 0;
        n_mem     = 0;
        n_unknown = 0;
        idle_on   = 1'b1;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        for (int i = 0; i < REG_COUNT; i++)
            reg_file[i] = '0;
        for (int i = 0; i < MEM_DEPTH; i++)
            data_mem[i] = '0;
        for (int i = 0; i < IO_REG_COUNT; i++)
            io_regs[i] = '0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_alu_ops();
        test_branches();
        test_memory();
        test_io();
        wait_for_results();
        test_random_traffic(1300, 1'b1);
        // full drain before the final back-to-back stretch
        wait_for_results();
        test_random_traffic(450, 1'b0);
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Executed %0d instructions, checked %0d results: %0d redirects, %0d I/O ops,",
                 n_sent, n_checked, n_taken, n_io);
        $display("%0d memory ops and %0d undefined opcodes, with and without stalls.",
                 n_mem, n_unknown);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/sre_pkg.sv
hw/rtl/simple_risc_execute_unit.sv
test/simple_risc_execute_unit_tb.sv
